// ===== rtl/itrd_pkg.sv =====
// Shared widths, register indexes and types for the integer to radix digit converter.
package itrd_pkg;

	localparam int MAG_W          = 32;
	localparam int RADIX_W        = 16;
	localparam int MIN_W          = 7;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 16;
	localparam int MAX_DIGITS_DEF = 64;
	localparam int STEP_W         = $clog2(MAG_W);

	localparam logic [RADIX_W-1:0] RADIX_RST = RADIX_W'(10);
	localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
	localparam logic [MIN_W-1:0]   MIN_RST   = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIX      = 2'd0,
		REG_MIN_DIGITS = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [MAG_W-1:0]   quo;
		logic [RADIX_W-1:0] rem;
	} div_res_t;

endpackage

// ===== rtl/integer_to_radix_digits.sv =====
// Top level: converts a signed 32-bit integer into radix digits, most significant first.
//
// The magnitude of each accepted value is split into digits by a bit-serial divider that
// works out all 32 quotient bits for each digit, least significant digit first; digits
// are kept in a RAM and then sent out most significant first, preceded by leading zeros
// up to min_digits, with last set on the final digit. One item is in work at a time, and
// a zero value counts one digit. Each output digit is held until out_ready. radix below 2
// acts as 2; min_digits above MAX_DIGITS acts as MAX_DIGITS. Write configuration only
// while the block is idle.
module integer_to_radix_digits #(
	parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [itrd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [itrd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [itrd_pkg::MAG_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [itrd_pkg::RADIX_W-1:0]      digit,
	output logic                              last
);
	import itrd_pkg::*;

	localparam int AW = $clog2(MAX_DIGITS);
	localparam int CW = $clog2(MAX_DIGITS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_DIV,
		S_RD,
		S_LD,
		S_WAIT
	} state_t;

	state_t              state_q;
	logic [RADIX_W-1:0]  radix_q;
	logic [MIN_W-1:0]    min_digits_q;
	logic [MAG_W-1:0]    mag_q;
	logic [CW-1:0]       n_q;
	logic [CW-1:0]       want_q;
	logic [AW-1:0]       k_q;
	logic [RADIX_W-1:0]  digit_q;
	logic                last_q;
	logic                out_valid_q;

	logic [RADIX_W-1:0]  base;
	logic [MAG_W-1:0]    mag_in;
	logic [CW-1:0]       total;
	logic                div_start;
	logic                div_done;
	div_res_t            div_res;
	logic                ram_we;
	logic [RADIX_W-1:0]  ram_rdata;

	assign base      = (radix_q < RADIX_MIN) ? RADIX_MIN : radix_q;
	assign mag_in    = value[MAG_W-1] ? (~value + MAG_W'(1)) : value;
	assign total     = (n_q > want_q) ? n_q : want_q;
	assign div_start = (state_q == S_START) && !((n_q != '0) && (mag_q == '0));
	assign ram_we    = (state_q == S_DIV) && div_done;
	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);

	itrd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_q),
		.divisor  (base),
		.done     (div_done),
		.res      (div_res)
	);

	itrd_ram #(
		.WIDTH (RADIX_W),
		.DEPTH (MAX_DIGITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (n_q[AW-1:0]),
		.wdata (div_res.rem),
		.raddr (k_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			radix_q      <= RADIX_RST;
			min_digits_q <= MIN_RST;
			mag_q        <= '0;
			n_q          <= '0;
			want_q       <= '0;
			k_q          <= '0;
			digit_q      <= '0;
			last_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_RADIX:      radix_q <= cfg_data;
					REG_MIN_DIGITS: min_digits_q <= cfg_data[MIN_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mag_q   <= mag_in;
						n_q     <= '0;
						want_q  <= (min_digits_q > MIN_W'(MAX_DIGITS)) ?
							CW'(MAX_DIGITS) : CW'(min_digits_q);
						state_q <= S_START;
					end
				end
				S_START: begin
					if ((n_q != '0) && (mag_q == '0)) begin
						k_q     <= AW'(total - CW'(1));
						state_q <= S_RD;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						mag_q   <= div_res.quo;
						n_q     <= n_q + CW'(1);
						state_q <= S_START;
					end
				end
				S_RD: begin
					state_q <= S_LD;
				end
				S_LD: begin
					digit_q     <= (CW'(k_q) >= n_q) ? '0 : ram_rdata;
					last_q      <= (k_q == '0);
					out_valid_q <= 1'b1;
					state_q     <= S_WAIT;
				end
				S_WAIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q - AW'(1);
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign digit     = digit_q;
	assign last      = last_q;

endmodule

// ===== rtl/itrd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module itrd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/itrd_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module itrd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [itrd_pkg::MAG_W-1:0]    dividend,
	input  logic [itrd_pkg::RADIX_W-1:0]  divisor,
	output logic                          done,
	output itrd_pkg::div_res_t            res
);
	import itrd_pkg::*;

	logic                run_q;
	logic                done_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [MAG_W-1:0]    quo_q;
	logic [RADIX_W-1:0]  rem_q;
	logic [RADIX_W:0]    trial;
	logic                fits;

	assign trial = {rem_q, quo_q[MAG_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= STEP_W'(MAG_W - 1);
				quo_q <= dividend;
				rem_q <= '0;
			end else if (run_q) begin
				quo_q <= {quo_q[MAG_W-2:0], fits};
				rem_q <= fits ? RADIX_W'(trial - {1'b0, divisor}) : RADIX_W'(trial);
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done    = done_q;
	assign res.quo = quo_q;
	assign res.rem = rem_q;

endmodule

// ===== bench/integer_to_radix_digits_checker.sv =====
// Checker for integer_to_radix_digits: tracks registers, predicts digits and compares results.
`timescale 1ns / 100ps
module integer_to_radix_digits_checker #(
	parameter int MAX_DIGITS = itrd_pkg::MAX_DIGITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [itrd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [itrd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic signed [itrd_pkg::MAG_W-1:0] value,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic [itrd_pkg::RADIX_W-1:0]      digit,
	input  logic                              last,
	output int                                mismatches,
	output int                                digits_pending,
	output int                                values_seen,
	output int                                digits_seen
);
	import itrd_pkg::*;

	typedef struct packed {
		logic [RADIX_W-1:0] digit;
		logic               last;
	} digit_beat_t;

	digit_beat_t        digits_due[$];
	digit_beat_t        oldest;
	logic [RADIX_W-1:0] radix_q;
	logic [MIN_W-1:0]   min_digits_q;

	initial begin
		mismatches = 0;
		digits_pending = 0;
		values_seen = 0;
		digits_seen = 0;
	end

	task automatic report_mismatch(input string what);
		if (mismatches < 40) begin
			$display("%0t ns: mismatch: %s", $time, what);
		end
		mismatches++;
	endtask

	// magnitude split least significant first, then queued most significant first
	task automatic expand_value(input logic [MAG_W-1:0] v);
		logic [MAG_W:0]     mag;
		logic [RADIX_W:0]   base;
		int                 want;
		int                 n;
		logic [RADIX_W-1:0] lsd_first[MAX_DIGITS];
		mag = v[MAG_W-1] ? {1'b0, ~v + 32'd1} : {1'b0, v};
		base = (radix_q < RADIX_MIN) ? (RADIX_W+1)'(RADIX_MIN) : {1'b0, radix_q};
		want = (int'(min_digits_q) > MAX_DIGITS) ? MAX_DIGITS : int'(min_digits_q);
		n = 0;
		while (n < MAX_DIGITS && (n == 0 || mag != '0 || n < want)) begin
			lsd_first[n] = RADIX_W'(mag % base);
			mag = mag / base;
			n++;
		end
		for (int k = 0; k < n; k++) begin
			digits_due.push_back('{digit: lsd_first[n - 1 - k], last: (k + 1 == n)});
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q = RADIX_RST;
			min_digits_q = MIN_RST;
			digits_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_RADIX) begin
					radix_q = cfg_data[RADIX_W-1:0];
				end else if (cfg_index == REG_MIN_DIGITS) begin
					min_digits_q = cfg_data[MIN_W-1:0];
				end
			end
			if (in_valid && in_ready) begin
				expand_value(value);
				values_seen++;
			end
			if (out_valid && out_ready) begin
				digits_seen++;
				if (digits_due.size() == 0) begin
					report_mismatch($sformatf("digit %0d last %b with nothing expected",
						digit, last));
				end else begin
					oldest = digits_due.pop_front();
					if (digit !== oldest.digit) begin
						report_mismatch($sformatf("digit %0d, expected %0d",
							digit, oldest.digit));
					end
					if (last !== oldest.last) begin
						report_mismatch($sformatf("last %b, expected %b on digit %0d",
							last, oldest.last, oldest.digit));
					end
				end
			end
		end
		digits_pending = digits_due.size();
	end

endmodule

// ===== bench/integer_to_radix_digits_test.sv =====
// Top of the integer_to_radix_digits bench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 100ps
module integer_to_radix_digits_test;
	import itrd_pkg::*;

	localparam int                   CYCLE_LIMIT   = 4_000_000;
	localparam int                   HOLD_CYCLES   = 900;
	localparam logic [MAG_W-1:0]     MOST_NEGATIVE = 32'h8000_0000;
	localparam logic [MAG_W-1:0]     MOST_POSITIVE = 32'h7FFF_FFFF;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3   = 2'd3;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic signed [MAG_W-1:0]   value;
	logic                      out_valid;
	logic                      out_ready;
	logic [RADIX_W-1:0]        digit;
	logic                      last;

	int mismatches;
	int digits_pending;
	int values_seen;
	int digits_seen;
	int idle_pct;
	int stall_pct;
	int hold_off_left;
	int settings_used;
	int cycle_count;
	int unsigned radix_now;

	integer_to_radix_digits dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.digit     (digit),
		.last      (last)
	);

	integer_to_radix_digits_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.value          (value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.digit          (digit),
		.last           (last),
		.mismatches     (mismatches),
		.digits_pending (digits_pending),
		.values_seen    (values_seen),
		.digits_seen    (digits_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off while the sender keeps offering
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				out_ready = 1'b0;
				hold_off_left--;
			end else begin
				out_ready = ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// entered and left just after a falling edge
	task automatic offer_value(input logic [MAG_W-1:0] v);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		value = v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_drained(input int extra);
		while (digits_pending != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic apply_setting(input logic [CFG_DATA_W-1:0] radix_data,
		input logic [CFG_DATA_W-1:0] min_data);
		wait_drained(8);
		write_reg(REG_RADIX, radix_data);
		write_reg(REG_MIN_DIGITS, min_data);
		radix_now = radix_data;
		settings_used++;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_radix();
		case ($urandom_range(15))
			0:       return CFG_DATA_W'($urandom_range(1));
			1:       return CFG_DATA_W'(2);
			2:       return CFG_DATA_W'(65535);
			3:       return CFG_DATA_W'($urandom_range(32768, 65535));
			4, 5, 6, 7, 8: return CFG_DATA_W'($urandom_range(3, 16));
			9, 10, 11, 12: return CFG_DATA_W'($urandom_range(17, 255));
			default: return CFG_DATA_W'($urandom_range(256, 32767));
		endcase
	endfunction

	// upper data bits are random; only the low seven bits matter
	function automatic logic [CFG_DATA_W-1:0] pick_min_data();
		logic [MIN_W-1:0] m;
		case ($urandom_range(9))
			0:       m = MIN_W'($urandom_range(65, 127));
			1:       m = MIN_W'(64);
			default: m = MIN_W'($urandom_range(0, 12));
		endcase
		return {(CFG_DATA_W-MIN_W)'($urandom), m};
	endfunction

	function automatic logic [MAG_W-1:0] pick_value(input int unsigned r);
		longint           eff;
		longint           p;
		logic [MAG_W-1:0] v;
		eff = (r < 2) ? 2 : r;
		case ($urandom_range(9))
			0: v = '0;
			1: begin
				case ($urandom_range(2))
					0:       v = MOST_NEGATIVE;
					1:       v = MOST_POSITIVE;
					default: v = '1;
				endcase
			end
			2, 3: v = MAG_W'($urandom_range(0, 2 * eff));
			4: begin
				p = eff;
				repeat ($urandom_range(0, 3)) begin
					if (p * eff < 64'h8000_0000) p = p * eff;
				end
				v = MAG_W'(p - $urandom_range(0, 1));
			end
			default: v = $urandom;
		endcase
		if (v != MOST_NEGATIVE && $urandom_range(1)) v = -v;
		return v;
	endfunction

	int idle_of[4]  = '{0, 53, 0, 36};
	int stall_of[4] = '{0, 0, 53, 36};

	initial begin
		cfg_valid = 1'b0;
		cfg_index = REG_RADIX;
		cfg_data = '0;
		in_valid = 1'b0;
		value = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_off_left = 0;
		settings_used = 1;
		radix_now = RADIX_RST;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: decimal, no padding
		offer_value('0);
		offer_value(32'd1);
		offer_value('1);
		offer_value(32'd9);
		offer_value(32'd10);
		offer_value(MOST_POSITIVE);
		offer_value(MOST_NEGATIVE);
		offer_value(-32'sd12345);

		apply_setting(16'd2, 16'd0);
		offer_value(MOST_NEGATIVE);
		offer_value(MOST_POSITIVE);
		offer_value('0);

		// widest radix; padding field with junk in the upper bits
		apply_setting(16'd65535, 16'hFF83);
		offer_value(MOST_NEGATIVE);
		offer_value(32'd65534);
		offer_value(-32'sd65535);

		// radix below two acts as two
		apply_setting(16'd0, 16'd0);
		offer_value(32'd5);
		apply_setting(16'd1, 16'd0);
		offer_value(-32'sd6);

		apply_setting(16'd2, 16'd64);
		offer_value('0);
		offer_value(MOST_NEGATIVE);

		// padding beyond capacity saturates
		apply_setting(16'd7, 16'h007F);
		offer_value(32'd7);

		// writes to unused indexes are dropped
		wait_drained(8);
		write_reg(REG_SPARE_2, 16'hFFFF);
		write_reg(REG_SPARE_3, 16'h0001);
		offer_value(32'd100);

		apply_setting(16'd32768, 16'd65);
		offer_value('1);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_of[ph];
			stall_pct = stall_of[ph];
			for (int blk = 0; blk < 4; blk++) begin
				apply_setting(pick_radix(), pick_min_data());
				if ($urandom_range(3) == 0) begin
					write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
						CFG_DATA_W'($urandom));
				end
				if (ph == 0 && blk == 1) hold_off_left = HOLD_CYCLES;
				for (int i = 0; i < 23; i++) begin
					offer_value(pick_value(radix_now));
				end
			end
		end

		wait_drained(100);
		$display("Converted %0d values into %0d digits under %0d register settings.",
			values_seen, digits_seen, settings_used);
		$display("Radix 0 to 65535, padding 0 to 127, with gaps, stalls and a long hold-off.");
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/itrd_pkg.sv
rtl/itrd_ram.sv
rtl/itrd_div.sv
rtl/integer_to_radix_digits.sv
bench/integer_to_radix_digits_checker.sv
bench/integer_to_radix_digits_test.sv
